// ----- rtl/aligned_first_fit_block_allocator_core_defines.svh -----
// assertion macros used by the checker file
`ifndef ALIGNED_FIRST_FIT_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define ALIGNED_FIRST_FIT_BLOCK_ALLOCATOR_CORE_DEFINES_SVH

// clocked check, muted while reset is asserted
`define AFFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked check that also holds across reset
`define AFFA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/affa_pkg.sv -----
// shared constants and types of the block allocator
`timescale 1ns / 1ps
package affa_pkg;

  localparam int MAX_BLOCKS = 64;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int OFF_W      = 24;
  localparam int LEN_W      = OFF_W + 1;
  localparam int UOFF_W     = 22;
  localparam int NEED_W     = 23;
  localparam int SPLIT_MIN  = 64 + 12;
  localparam logic [20:0] REQ_LIMIT = 21'h100000;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_INIT,
    OP_ALLOC,
    OP_FREE,
    OP_MERGE
  } cell_op_e;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_CHECK = 2'd2,
    CMD_BAD   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_REQ = 2'd1,
    ST_NO_FIT  = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_e;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    cell_op_e          op;
    logic [IDX_W-1:0]  k;
    logic              go;
    logic              split;
    logic [LEN_W-1:0]  init_len;
    logic [31:0]       base;
    logic [21:0]       c1;
    logic [20:0]       amask;
    logic [20:0]       size;
    logic [31:0]       rel;
  } cell_cmd_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic              vld;
    logic              used;
    logic [OFF_W-1:0]  off;
    logic [LEN_W-1:0]  len;
    logic [OFF_W-1:0]  uoff;
    logic [NEED_W-1:0] need;
  } cell_nb_t;

endpackage

// ----- rtl/affa_cell.sv -----
// one table entry with its local fit pipeline and shift links
`timescale 1ns / 1ps
module affa_cell import affa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] idx_i,
  input  cell_cmd_t        cmd_i,
  input  cell_nb_t         prev_i,
  input  cell_nb_t         next_i,
  output cell_nb_t         self_o,
  output logic             hit_o,
  output logic             split_o,
  output logic [31:0]      p_o,
  output logic             match_o,
  output logic             free_o
);

  logic              vld_q, vld_d, used_q, used_d;
  logic [OFF_W-1:0]  off_q, off_d, uoff_q, uoff_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [32:0]       baddr_q;
  logic [33:0]       p_q;
  logic [UOFF_W-1:0] du_q;
  logic [NEED_W-1:0] need_q;
  logic              here, fit;
  logic [IDX_W:0]    idx_x, k_x;

  assign idx_x = {1'b0, idx_i};
  assign k_x   = {1'b0, cmd_i.k};
  assign here  = (idx_i == cmd_i.k);
  assign fit   = vld_q && !used_q && (32'(need_q) <= 32'(len_q)) && (p_q[33:32] == 2'b00);

  assign hit_o   = here && fit;
  assign split_o = here && ((32'(len_q) - 32'(need_q)) >= 32'(SPLIT_MIN));
  assign p_o     = hit_o ? p_q[31:0] : 32'd0;
  assign match_o = here && vld_q && used_q && (32'(uoff_q) == cmd_i.rel);
  assign free_o  = vld_q && !used_q;

  assign self_o = '{vld: vld_q, used: used_q, off: off_q, len: len_q,
                    uoff: uoff_q, need: need_q};

  // fit pipeline: base address and aligned user address, then offset, then rounded need
  always_ff @(posedge clk_i) begin
    baddr_q <= 33'(cmd_i.base) + 33'(off_q);
    p_q     <= (34'(cmd_i.base) + 34'(off_q) + 34'(cmd_i.c1)) & ~34'(cmd_i.amask);
    du_q    <= UOFF_W'(p_q - 34'(baddr_q));
    need_q  <= (NEED_W'(du_q) + NEED_W'(cmd_i.size) + NEED_W'(3)) & ~NEED_W'(3);
  end

  always_comb begin
    vld_d  = vld_q;
    used_d = used_q;
    off_d  = off_q;
    len_d  = len_q;
    uoff_d = uoff_q;
    case (cmd_i.op)
      OP_INIT: begin
        vld_d  = (idx_i == '0);
        used_d = 1'b0;
        off_d  = '0;
        len_d  = (idx_i == '0) ? cmd_i.init_len : '0;
      end
      OP_ALLOC: begin
        if (cmd_i.go) begin
          if (here) begin
            used_d = 1'b1;
            uoff_d = off_q + OFF_W'(du_q);
            if (cmd_i.split) len_d = LEN_W'(need_q);
          end else if (cmd_i.split && idx_x == k_x + 1'b1) begin
            vld_d  = 1'b1;
            used_d = 1'b0;
            off_d  = prev_i.off + OFF_W'(prev_i.need);
            len_d  = prev_i.len - LEN_W'(prev_i.need);
            uoff_d = '0;
          end else if (cmd_i.split && idx_x > k_x + 1'b1) begin
            vld_d  = prev_i.vld;
            used_d = prev_i.used;
            off_d  = prev_i.off;
            len_d  = prev_i.len;
            uoff_d = prev_i.uoff;
          end
        end
      end
      OP_FREE: begin
        if (cmd_i.go && here) used_d = 1'b0;
      end
      OP_MERGE: begin
        if (here) begin
          len_d = len_q + next_i.len;
        end else if (idx_x > k_x) begin
          vld_d  = next_i.vld;
          used_d = next_i.used;
          off_d  = next_i.off;
          len_d  = next_i.len;
          uoff_d = next_i.uoff;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= (idx_i == '0);
      used_q <= 1'b0;
      off_q  <= '0;
      len_q  <= (idx_i == '0) ? LEN_W'(32'h100000) : '0;
      uoff_q <= '0;
    end else begin
      vld_q  <= vld_d;
      used_q <= used_d;
      off_q  <= off_d;
      len_q  <= len_d;
      uoff_q <= uoff_d;
    end
  end

endmodule

// ----- rtl/aligned_first_fit_block_allocator_core.sv -----
`timescale 1ns / 1ps
// First-fit allocator over one region of region_size bytes at region_base. The block table
// lives in a row of MAX_BLOCKS cells, one block each, address ordered; inserting a split tail
// or merging two blocks shifts all the cells after it by one place in the same cycle. One request
// is worked at a time. An allocate first passes the per-cell fit pipeline (states S_P1, S_P2,
// S_P3) and then passes a search token one cell per cycle up to the first fitting block or the
// last valid one. A free walks the token the same way, then merges the freed block with a free
// right and then a free left neighbor (states S_MR, S_ML). A region check or a rejected request
// goes straight to S_DONE, which hands the result to the output register; this lets the next
// request in while a result waits. Writing either register resets the table to a single free
// block over the region (size clamped to 16 MiB); write only while the block is idle.
module aligned_first_fit_block_allocator_core import affa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [79:0] s_tdata_i,   // cmd[1:0], align_bytes[22:2], size_bytes[43:23], address[75:44]
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [39:0] m_tdata_o,   // result_address[31:0], status[33:32], in_region[34]
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_P1, S_P2, S_P3, S_ASCAN, S_FSCAN, S_MR, S_ML, S_DONE
  } state_e;

  state_e            state_q;
  logic [31:0]       base_q;
  logic [24:0]       rsize_q;
  logic [21:0]       c1_q;
  logic [20:0]       amask_q, size_q;
  logic [31:0]       rel_q;
  logic [IDX_W-1:0]  k_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [31:0]       res_addr_q;
  status_e           res_st_q;
  logic              inr_q;
  logic              m_vld_q;
  logic [34:0]       m_data_q;

  // request fields
  logic [1:0]  in_cmd;
  logic [20:0] in_align, in_size, al_eff;
  logic [31:0] in_addr;
  logic        acc, bad_alloc, in_region, last_k;
  logic [32:0] reg_end;
  logic [LEN_W-1:0] init_len;
  logic [24:0] new_size;

  assign in_cmd   = s_tdata_i[1:0];
  assign in_align = s_tdata_i[22:2];
  assign in_size  = s_tdata_i[43:23];
  assign in_addr  = s_tdata_i[75:44];

  assign s_tready_o = (state_q == S_IDLE);
  assign acc        = s_tvalid_i && s_tready_o;

  assign bad_alloc = (in_size == '0) || (in_size > REQ_LIMIT) || (in_align == '0) ||
                     (in_align > REQ_LIMIT) || ((in_align & (in_align - 21'd1)) != '0);
  // alignments of 1 and 2 are raised to a word
  assign al_eff    = (in_align < 21'd4) ? 21'd4 : in_align;

  assign reg_end   = 33'(base_q) + 33'(rsize_q);
  assign in_region = (in_addr >= base_q) && (33'(in_addr) < reg_end);

  // table length after a register write, clamped to the offset range
  assign new_size = cfg_idx_i ? cfg_wdata_i[24:0] : rsize_q;
  assign init_len = (32'(new_size) > (32'd1 << OFF_W)) ? LEN_W'(32'd1 << OFF_W)
                                                       : LEN_W'(new_size);

  assign last_k = (CNT_W'(k_q) + CNT_W'(1)) == cnt_q;

  // cell row
  cell_cmd_t                cmd;
  cell_nb_t                 nb     [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0]    hit_v, split_v, match_v, free_v;
  logic [31:0]              p_v    [MAX_BLOCKS];
  logic                     hit_any, split_any, match_any;
  logic [31:0]              p_any;
  logic                     free_nx, free_pv;

  for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
    cell_nb_t prev_nb, next_nb;
    if (g == 0) begin : g_first
      assign prev_nb = '0;
    end else begin : g_mid
      assign prev_nb = nb[g-1];
    end
    if (g == MAX_BLOCKS - 1) begin : g_last
      assign next_nb = '0;
    end else begin : g_inner
      assign next_nb = nb[g+1];
    end
    affa_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (IDX_W'(g)),
      .cmd_i   (cmd),
      .prev_i  (prev_nb),
      .next_i  (next_nb),
      .self_o  (nb[g]),
      .hit_o   (hit_v[g]),
      .split_o (split_v[g]),
      .p_o     (p_v[g]),
      .match_o (match_v[g]),
      .free_o  (free_v[g])
    );
  end

  // only the token cell can report, so plain or-reduction picks its values
  always_comb begin
    p_any = '0;
    for (int i = 0; i < MAX_BLOCKS; i++) p_any = p_any | p_v[i];
  end
  assign hit_any   = |hit_v;
  assign split_any = |(split_v & hit_v);
  assign match_any = |match_v;

  // neighbor free marks around the freed block
  assign free_nx = (k_q != IDX_W'(MAX_BLOCKS - 1)) && free_v[k_q + IDX_W'(1)];
  assign free_pv = (k_q != '0) && free_v[k_q - IDX_W'(1)];

  always_comb begin
    cmd          = '0;
    cmd.op       = OP_IDLE;
    cmd.k        = k_q;
    cmd.init_len = init_len;
    cmd.base     = base_q;
    cmd.c1       = c1_q;
    cmd.amask    = amask_q;
    cmd.size     = size_q;
    cmd.rel      = rel_q;
    case (state_q)
      S_IDLE:  if (cfg_we_i) cmd.op = OP_INIT;
      S_ASCAN: begin
        cmd.op    = OP_ALLOC;
        cmd.go    = hit_any;
        cmd.split = split_any && (cnt_q != CNT_W'(MAX_BLOCKS));
      end
      S_FSCAN: begin
        cmd.op = OP_FREE;
        cmd.go = match_any;
      end
      S_MR:    if (free_nx) cmd.op = OP_MERGE;
      S_ML: begin
        cmd.k = k_q - IDX_W'(1);
        if (free_pv) cmd.op = OP_MERGE;
      end
      default: ;
    endcase
  end

  // sequencer, result and output registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      base_q     <= '0;
      rsize_q    <= 25'h100000;
      cnt_q      <= CNT_W'(1);
      k_q        <= '0;
      m_vld_q    <= 1'b0;
      res_st_q   <= ST_OK;
      res_addr_q <= '0;
      inr_q      <= 1'b0;
      m_data_q   <= '0;
      c1_q       <= '0;
      amask_q    <= '0;
      size_q     <= '0;
      rel_q      <= '0;
    end else begin
      if (m_vld_q && m_tready_i) m_vld_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (cfg_we_i) begin
            if (cfg_idx_i) rsize_q <= cfg_wdata_i[24:0];
            else           base_q  <= cfg_wdata_i;
            cnt_q <= CNT_W'(1);
          end
          if (acc) begin
            inr_q      <= in_region;
            res_addr_q <= '0;
            res_st_q   <= ST_OK;
            k_q        <= '0;
            c1_q       <= 22'(al_eff) + 22'd15;
            amask_q    <= al_eff - 21'd1;
            size_q     <= in_size;
            rel_q      <= in_addr - base_q;
            case (in_cmd)
              CMD_ALLOC: begin
                if (bad_alloc) begin
                  res_st_q <= ST_BAD_REQ;
                  state_q  <= S_DONE;
                end else begin
                  state_q <= S_P1;
                end
              end
              CMD_FREE: begin
                if (in_addr == '0) begin
                  state_q <= S_DONE;
                end else if (in_addr < base_q) begin
                  res_st_q <= ST_UNKNOWN;
                  state_q  <= S_DONE;
                end else begin
                  state_q <= S_FSCAN;
                end
              end
              CMD_CHECK: state_q <= S_DONE;
              default: begin
                res_st_q <= ST_BAD_REQ;
                state_q  <= S_DONE;
              end
            endcase
          end
        end
        S_P1: state_q <= S_P2;
        S_P2: state_q <= S_P3;
        S_P3: state_q <= S_ASCAN;
        S_ASCAN: begin
          if (hit_any) begin
            res_addr_q <= p_any;
            if (cmd.split) cnt_q <= cnt_q + CNT_W'(1);
            state_q <= S_DONE;
          end else if (last_k) begin
            res_st_q <= ST_NO_FIT;
            state_q  <= S_DONE;
          end else begin
            k_q <= k_q + IDX_W'(1);
          end
        end
        S_FSCAN: begin
          if (match_any) begin
            state_q <= S_MR;
          end else if (last_k) begin
            res_st_q <= ST_UNKNOWN;
            state_q  <= S_DONE;
          end else begin
            k_q <= k_q + IDX_W'(1);
          end
        end
        S_MR: begin
          if (free_nx) cnt_q <= cnt_q - CNT_W'(1);
          state_q <= S_ML;
        end
        S_ML: begin
          if (free_pv) cnt_q <= cnt_q - CNT_W'(1);
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!m_vld_q || m_tready_i) begin
            m_vld_q  <= 1'b1;
            m_data_q <= {inr_q, res_st_q, res_addr_q};
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_tvalid_o = m_vld_q;
  assign m_tdata_o  = {5'd0, m_data_q};

endmodule

// ----- rtl/affa_chk.sv -----
// port-level checks of the block allocator and their bind
`timescale 1ns / 1ps
`include "aligned_first_fit_block_allocator_core_defines.svh"
module affa_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_tvalid_i,
  input logic        s_tready_o,
  input logic        m_tvalid_o,
  input logic        m_tready_i,
  input logic [39:0] m_tdata_o
);

  `AFFA_ASSERT(a_out_hold, m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o), "result changed while stalled")
  `AFFA_ASSERT(a_addr_ok, m_tvalid_o && (m_tdata_o[31:0] != 32'd0) |-> (m_tdata_o[33:32] == 2'd0), "address returned with error status")
  `AFFA_ASSERT(a_busy, s_tvalid_i && s_tready_o |=> !s_tready_o, "request taken while another is in work")
  `AFFA_ASSERT_ALWAYS(a_pad, m_tdata_o[39:35] == 5'd0, "result padding not zero")

endmodule

bind aligned_first_fit_block_allocator_core affa_chk u_affa_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_tvalid_i),
  .s_tready_o (s_tready_o),
  .m_tvalid_o (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_o  (m_tdata_o)
);
